// File: rtl/slsmu_pkg.sv
// ----------------------------------------------------------------------------
// slsmu_pkg
// shared types, codes and helper functions of the sized load/store unit
// ----------------------------------------------------------------------------
package slsmu_pkg;

    localparam int unsigned DefMemBytes = 65536;

    // configuration port
    localparam int unsigned CfgAddrW = 4;
    localparam logic REG_BASE_ADDRESS = 1'b0;

    // request kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_STORE = 1'b1;

    // access sizes
    localparam logic [1:0] SZ_BYTE   = 2'd0;
    localparam logic [1:0] SZ_HALF   = 2'd1;
    localparam logic [1:0] SZ_WORD   = 2'd2;
    localparam logic [1:0] SZ_DOUBLE = 2'd3;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_MISALIGNED = 2'd1,
        ST_RANGE      = 2'd2
    } status_t;

    typedef struct packed {
        logic        kind;
        logic [63:0] address;
        logic [1:0]  size_code;
        logic [63:0] store_value;
        logic        sign_extend;
    } req_t;

    typedef struct packed {
        logic [63:0] load_value;
        status_t     status;
    } rsp_t;

    // checked access handed from the check stage to the memory stage
    typedef struct packed {
        status_t     status;
        logic        kind;
        logic [1:0]  size_code;
        logic        sign_extend;
        logic [2:0]  lane;
        logic [7:0]  wbe;
        logic [63:0] wdata;
    } acc_t;

    function automatic logic [7:0] lane_mask(input logic [1:0] size_code);
        logic [7:0] m;
        unique case (size_code)
            SZ_BYTE:   m = 8'h01;
            SZ_HALF:   m = 8'h03;
            SZ_WORD:   m = 8'h0f;
            SZ_DOUBLE: m = 8'hff;
        endcase
        return m;
    endfunction

    function automatic logic [63:0] extract_load(
        input logic [63:0] word,
        input logic [2:0]  lane,
        input logic [1:0]  size_code,
        input logic        sext
    );
        logic [63:0] shifted;
        logic [63:0] r;
        shifted = word >> {lane, 3'b000};
        unique case (size_code)
            SZ_BYTE:   r = {{56{sext & shifted[7]}}, shifted[7:0]};
            SZ_HALF:   r = {{48{sext & shifted[15]}}, shifted[15:0]};
            SZ_WORD:   r = {{32{sext & shifted[31]}}, shifted[31:0]};
            SZ_DOUBLE: r = shifted;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/slsmu_apb.sv
// ----------------------------------------------------------------------------
// slsmu_apb
// configuration register port, holds the base address
// ----------------------------------------------------------------------------
module slsmu_apb
    import slsmu_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CfgAddrW-1:0] paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    output logic [63:0]         base_address
);

    logic [63:0] base_address_reg;
    logic [63:0] base_address_next;
    logic        wr_en;
    logic        sel_base;

    assign pready   = 1'b1;
    assign sel_base = (paddr[CfgAddrW-1:3] == REG_BASE_ADDRESS);
    assign wr_en    = psel && penable && pwrite && pready;

    always_comb
    begin
        base_address_next = base_address_reg;
        if (wr_en && sel_base)
        begin
            base_address_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg <= '0;
        end
        else
        begin
            base_address_reg <= base_address_next;
        end
    end

    assign prdata       = sel_base ? base_address_reg : 64'd0;
    assign base_address = base_address_reg;

endmodule

// File: rtl/slsmu_check.sv
// ----------------------------------------------------------------------------
// slsmu_check
// first stage: registers the request with its memory offset, then checks
// alignment and bounds and steers store data onto byte lanes
// ----------------------------------------------------------------------------
module slsmu_check
    import slsmu_pkg::*;
#(
    parameter int unsigned MEM_BYTES = DefMemBytes
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [63:0] base_address,
    input  req_t        req,
    input  logic        load,
    input  logic        drain,
    output logic        valid,
    output acc_t        acc,
    output logic [((MEM_BYTES + 7) / 8 > 1 ? $clog2((MEM_BYTES + 7) / 8) : 1)-1:0] word_idx
);

    localparam int unsigned WordCount = (MEM_BYTES + 7) / 8;
    localparam int unsigned WordAw    = WordCount > 1 ? $clog2(WordCount) : 1;
    localparam logic [63:0] MemBytes64 = 64'(MEM_BYTES);
    localparam logic [63:0] LimByte    = MemBytes64 - 64'd1;
    localparam logic [63:0] LimHalf    = MemBytes64 - 64'd2;
    localparam logic [63:0] LimWord    = MemBytes64 - 64'd4;
    localparam logic [63:0] LimDouble  = MemBytes64 - 64'd8;

    logic        valid_reg;
    logic        valid_next;
    logic        kind_reg;
    logic [1:0]  size_reg;
    logic        sext_reg;
    logic [63:0] value_reg;
    logic [63:0] offset_reg;

    logic        misaligned;
    logic [63:0] limit;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (drain)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= req.kind;
            size_reg   <= req.size_code;
            sext_reg   <= req.sign_extend;
            value_reg  <= req.store_value;
            offset_reg <= req.address - base_address;
        end
    end

    always_comb
    begin
        unique case (size_reg)
            SZ_BYTE:
            begin
                misaligned = 1'b0;
                limit      = LimByte;
            end
            SZ_HALF:
            begin
                misaligned = offset_reg[0];
                limit      = LimHalf;
            end
            SZ_WORD:
            begin
                misaligned = |offset_reg[1:0];
                limit      = LimWord;
            end
            SZ_DOUBLE:
            begin
                misaligned = |offset_reg[2:0];
                limit      = LimDouble;
            end
        endcase
    end

    // misalignment wins over range; a wrapped offset is huge and fails the bound
    always_comb
    begin
        priority if (misaligned)
        begin
            acc.status = ST_MISALIGNED;
        end
        else if (offset_reg > limit)
        begin
            acc.status = ST_RANGE;
        end
        else
        begin
            acc.status = ST_DONE;
        end
        acc.kind        = kind_reg;
        acc.size_code   = size_reg;
        acc.sign_extend = sext_reg;
        acc.lane        = offset_reg[2:0];
        acc.wbe         = lane_mask(size_reg) << offset_reg[2:0];
        acc.wdata       = value_reg << {offset_reg[2:0], 3'b000};
    end

    assign valid    = valid_reg;
    assign word_idx = offset_reg[3 +: WordAw];

endmodule

// File: rtl/slsmu_mem.sv
// ----------------------------------------------------------------------------
// slsmu_mem
// data memory of 64-bit words with byte write enables and registered read
// ----------------------------------------------------------------------------
module slsmu_mem
    import slsmu_pkg::*;
#(
    parameter int unsigned MEM_BYTES = DefMemBytes
)
(
    input  logic        clk,
    input  logic        en,
    input  logic        we,
    input  logic [((MEM_BYTES + 7) / 8 > 1 ? $clog2((MEM_BYTES + 7) / 8) : 1)-1:0] addr,
    input  logic [7:0]  wbe,
    input  logic [63:0] wdata,
    output logic [63:0] rdata
);

    localparam int unsigned WordCount = (MEM_BYTES + 7) / 8;

    logic [63:0] mem [WordCount];
    logic [63:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en && we)
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (wbe[i])
                begin
                    mem[addr][8*i +: 8] <= wdata[8*i +: 8];
                end
            end
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (en && !we)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/sized_load_store_memory_unit.sv
// ----------------------------------------------------------------------------
// sized_load_store_memory_unit
// byte-addressed little-endian data memory with sized, checked loads/stores
// ----------------------------------------------------------------------------
// Takes one load or store request per cycle when the response side does not
// stall, and returns one response per request, in order, through registered
// stages: a check stage subtracts the base address and tests alignment and
// bounds, a memory stage performs the byte-enabled write or the registered
// read of the addressed 64-bit word, and the response register holds the
// extended load data and status. Stores write only their byte lanes, so no
// read is needed for them.
// The base address is written over the APB port at byte address 0 and should
// only change while no request is in flight. Memory contents are undefined
// until written.
module sized_load_store_memory_unit
    import slsmu_pkg::*;
#(
    parameter int unsigned MEM_BYTES = DefMemBytes
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CfgAddrW-1:0] paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    input  logic                req_valid,
    output logic                req_ready,
    input  req_t                req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output rsp_t                rsp
);

    localparam int unsigned WordCount = (MEM_BYTES + 7) / 8;
    localparam int unsigned WordAw    = WordCount > 1 ? $clog2(WordCount) : 1;

    logic [63:0]       base_address;
    logic              chk_valid;
    acc_t              acc;
    logic [WordAw-1:0] word_idx;
    logic [63:0]       mem_rdata;

    logic              s1_take;
    logic              s2_take;
    logic              out_adv;
    logic              mem_en;

    logic              s2_valid_reg;
    logic              s2_valid_next;
    status_t           s2_status_reg;
    logic              s2_kind_reg;
    logic [1:0]        s2_size_reg;
    logic              s2_sext_reg;
    logic [2:0]        s2_lane_reg;

    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;

    slsmu_apb u_apb (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .base_address (base_address)
    );

    slsmu_check #(
        .MEM_BYTES (MEM_BYTES)
    ) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .base_address (base_address),
        .req          (req),
        .load         (s1_take),
        .drain        (s2_take),
        .valid        (chk_valid),
        .acc          (acc),
        .word_idx     (word_idx)
    );

    slsmu_mem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (acc.kind == KIND_STORE),
        .addr  (word_idx),
        .wbe   (acc.wbe),
        .wdata (acc.wdata),
        .rdata (mem_rdata)
    );

    // pipeline flow, each stage moves when the one after it has room
    assign out_adv   = s2_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign s2_take   = chk_valid && (!s2_valid_reg || out_adv);
    assign req_ready = !chk_valid || s2_take;
    assign s1_take   = req_valid && req_ready;
    assign mem_en    = s2_take && (acc.status == ST_DONE);

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (s2_take)
        begin
            s2_valid_next = 1'b1;
        end
        else if (out_adv)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (out_adv)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // refused accesses and stores answer zero
    always_comb
    begin
        rsp_next.status = s2_status_reg;
        if (s2_status_reg == ST_DONE && s2_kind_reg == KIND_LOAD)
        begin
            rsp_next.load_value = extract_load(mem_rdata, s2_lane_reg, s2_size_reg,
                                               s2_sext_reg);
        end
        else
        begin
            rsp_next.load_value = 64'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_take)
        begin
            s2_status_reg <= acc.status;
            s2_kind_reg   <= acc.kind;
            s2_size_reg   <= acc.size_code;
            s2_sext_reg   <= acc.sign_extend;
            s2_lane_reg   <= acc.lane;
        end
        if (out_adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
